### rtl/wildcard_signature_scan_patch_macros.svh
// Assertion helpers for the scan and patch block.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef WILDCARD_SIGNATURE_SCAN_PATCH_MACROS_SVH
`define WILDCARD_SIGNATURE_SCAN_PATCH_MACROS_SVH

// consequence must hold in the same cycle as the trigger
`define WSSP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence must hold in the cycle after the trigger
`define WSSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wssp_pkg.sv
package wssp_pkg;

	// line depth and derived widths
	localparam int MAX_PATTERN = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

	// stream field widths
	localparam int BYTE_W = 8;
	localparam int OFS_W  = 32;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MASK_W     = 16;
	localparam int LEN_W      = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HIGH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_MASK     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 3'd7;

	typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_row_t;

	// configuration view shared by every cell of the line
	typedef struct packed {
		byte_row_t              pattern;
		logic [MASK_W-1:0]      care;
		logic [CNT_W-1:0]       pat_len;  // effective pattern length, 1..MAX_PATTERN
		byte_row_t              replace;
		logic [MASK_W-1:0]      wmask;
		logic [CNT_W-1:0]       in_len;   // replacement bytes that land inside the window
	} cell_cfg_t;

	// byte k of a 16-byte row
	function automatic logic [BYTE_W-1:0] pick_byte(input byte_row_t row,
			input logic [IDX_W-1:0] k);
		return row[k];
	endfunction

endpackage

### rtl/wssp_if.sv
// input stream channel
interface wssp_in_if;
	logic                         valid;
	logic                         ready;
	logic [wssp_pkg::BYTE_W-1:0]  in_byte;
	logic                         in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// result channel
interface wssp_out_if;
	logic                         valid;
	logic                         ready;
	logic [wssp_pkg::BYTE_W-1:0]  out_byte;
	logic                         out_last;
	logic                         found;
	logic [wssp_pkg::OFS_W-1:0]   match_offset;

	modport source (output valid, output out_byte, output out_last, output found,
		output match_offset, input ready);
	modport sink (input valid, input out_byte, input out_last, input found,
		input match_offset, output ready);
endinterface

### rtl/wildcard_signature_scan_patch.sv
// Wildcard byte pattern search and patch. Bytes shift through a line of 16
// cells; each accepted byte is compared, in the same cycle, against the
// newest pattern_length bytes and the first match patches the line in place
// (replacement bytes past the window are applied to later input bytes).
// One byte is accepted per cycle except when draining or full and stalled;
// once the line holds 16 bytes each accepted byte pushes out the oldest one
// through a single output register, so a result appears in the cycle after
// the byte that caused it. The in_last byte starts a drain: the line
// empties through the output register one byte per cycle while the output
// is not stalled, and no input is taken until the final byte, flagged
// out_last, has been loaded. found and match_offset report the first match
// of the current stream; a stream shorter than the pattern never matches.
// Configuration writes should be made between streams.
module wildcard_signature_scan_patch (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wssp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wssp_pkg::CFG_DATA_W-1:0]     cfg_data,
	wssp_in_if.sink                             byte_ch,
	wssp_out_if.source                          result_ch
);

	localparam logic [wssp_pkg::OFS_W-1:0] OFS_MAX = '1;
	localparam logic [wssp_pkg::CNT_W-1:0] FULL    = wssp_pkg::CNT_W'(wssp_pkg::MAX_PATTERN);
	localparam logic [wssp_pkg::CNT_W-1:0] ONE     = wssp_pkg::CNT_W'(1);

	// configuration registers
	logic [wssp_pkg::CFG_DATA_W-1:0]  pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
	logic [wssp_pkg::MASK_W-1:0]      care_q, wmask_q;
	logic [wssp_pkg::LEN_W-1:0]       plen_q, rlen_q;

	// stream state
	logic [wssp_pkg::CNT_W-1:0]       fill_q;
	logic                             match_seen_q;
	logic [wssp_pkg::OFS_W-1:0]       byte_cnt_q;
	logic [wssp_pkg::OFS_W-1:0]       offset_q;
	logic [wssp_pkg::CNT_W-1:0]       patch_rem_q;
	logic                             drain_q;

	// output register
	logic                             out_valid_q;
	logic [wssp_pkg::BYTE_W-1:0]      out_byte_q;
	logic                             out_last_q;
	logic                             found_q;
	logic [wssp_pkg::OFS_W-1:0]       out_ofs_q;

	wssp_pkg::cell_cfg_t              ccfg;
	logic [wssp_pkg::CNT_W-1:0]       elen, erl;
	logic [wssp_pkg::CNT_W-1:0]       k_full;
	logic [wssp_pkg::BYTE_W-1:0]      new_byte;
	logic [wssp_pkg::CNT_W-1:0]       fill_next;
	logic [wssp_pkg::CNT_W-1:0]       drain_pos;
	logic                             in_acc, emit_full, out_free, drain_step, hit;
	logic [wssp_pkg::MAX_PATTERN-1:0] cell_match;
	logic [wssp_pkg::BYTE_W-1:0]      cell_q   [wssp_pkg::MAX_PATTERN];
	logic [wssp_pkg::BYTE_W-1:0]      cell_din [wssp_pkg::MAX_PATTERN];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '0;
			plen_q   <= wssp_pkg::LEN_W'(1);
			rep_lo_q <= '0;
			rep_hi_q <= '0;
			wmask_q  <= '0;
			rlen_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wssp_pkg::REG_PATTERN_LOW:    pat_lo_q <= cfg_data;
				wssp_pkg::REG_PATTERN_HIGH:   pat_hi_q <= cfg_data;
				wssp_pkg::REG_CARE_MASK:      care_q   <= cfg_data[wssp_pkg::MASK_W-1:0];
				wssp_pkg::REG_PATTERN_LENGTH: plen_q   <= cfg_data[wssp_pkg::LEN_W-1:0];
				wssp_pkg::REG_REPLACE_LOW:    rep_lo_q <= cfg_data;
				wssp_pkg::REG_REPLACE_HIGH:   rep_hi_q <= cfg_data;
				wssp_pkg::REG_WRITE_MASK:     wmask_q  <= cfg_data[wssp_pkg::MASK_W-1:0];
				wssp_pkg::REG_REPLACE_LENGTH: rlen_q   <= cfg_data[wssp_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// effective lengths, clamped to the line depth
	always_comb begin
		if (plen_q == '0) begin
			elen = ONE;
		end else if (wssp_pkg::CNT_W'(plen_q) > FULL) begin
			elen = FULL;
		end else begin
			elen = wssp_pkg::CNT_W'(plen_q);
		end
		erl = (wssp_pkg::CNT_W'(rlen_q) > FULL) ? FULL : wssp_pkg::CNT_W'(rlen_q);
	end

	always_comb begin
		ccfg.pattern = {pat_hi_q, pat_lo_q};
		ccfg.care    = care_q;
		ccfg.pat_len = elen;
		ccfg.replace = {rep_hi_q, rep_lo_q};
		ccfg.wmask   = wmask_q;
		ccfg.in_len  = (erl < elen) ? erl : elen;
	end

	// handshake
	assign emit_full     = fill_q == FULL;
	assign out_free      = !out_valid_q || result_ch.ready;
	assign byte_ch.ready = !drain_q && (!emit_full || out_free);
	assign in_acc        = byte_ch.valid && byte_ch.ready;
	assign drain_step    = drain_q && out_free;

	// tail of an accepted patch applied to the incoming byte
	assign k_full = erl - patch_rem_q;
	always_comb begin
		new_byte = byte_ch.in_byte;
		if (patch_rem_q != '0 && wmask_q[k_full[wssp_pkg::IDX_W-1:0]]) begin
			new_byte = wssp_pkg::pick_byte(ccfg.replace, k_full[wssp_pkg::IDX_W-1:0]);
		end
	end

	assign fill_next = emit_full ? FULL : fill_q + ONE;
	assign hit = in_acc && !match_seen_q && (fill_next >= elen) && (&cell_match);

	// the line: cell MAX_PATTERN-1 takes the new byte, the others their neighbor
	for (genvar j = 0; j < wssp_pkg::MAX_PATTERN; j++) begin : g_cell
		if (j == wssp_pkg::MAX_PATTERN - 1) begin : g_head
			assign cell_din[j] = new_byte;
		end else begin : g_body
			assign cell_din[j] = cell_q[j+1];
		end

		wssp_cell u_cell (
			.clk   (clk),
			.pos   (wssp_pkg::IDX_W'(j)),
			.cfg   (ccfg),
			.shift (in_acc),
			.din   (cell_din[j]),
			.hit   (hit),
			.match (cell_match[j]),
			.q     (cell_q[j])
		);
	end

	// oldest valid byte while draining
	assign drain_pos = FULL - fill_q;

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			match_seen_q <= 1'b0;
			byte_cnt_q   <= '0;
			offset_q     <= '0;
			patch_rem_q  <= '0;
			drain_q      <= 1'b0;
		end else if (in_acc) begin
			fill_q <= fill_next;
			if (byte_cnt_q != OFS_MAX) begin
				byte_cnt_q <= byte_cnt_q + wssp_pkg::OFS_W'(1);
			end
			if (patch_rem_q != '0) begin
				patch_rem_q <= patch_rem_q - ONE;
			end
			if (hit) begin
				match_seen_q <= 1'b1;
				offset_q     <= (byte_cnt_q == OFS_MAX) ? OFS_MAX
					: byte_cnt_q + wssp_pkg::OFS_W'(1) - wssp_pkg::OFS_W'(elen);
				patch_rem_q  <= (erl > elen) ? erl - elen : '0;
			end
			if (byte_ch.in_last) begin
				drain_q <= 1'b1;
			end
		end else if (drain_step) begin
			fill_q <= fill_q - ONE;
			if (fill_q == ONE) begin
				drain_q      <= 1'b0;
				match_seen_q <= 1'b0;
				byte_cnt_q   <= '0;
				offset_q     <= '0;
				patch_rem_q  <= '0;
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_acc && emit_full) || drain_step) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_acc && emit_full) begin
			out_byte_q <= cell_q[0];
			out_last_q <= 1'b0;
			found_q    <= match_seen_q;
			out_ofs_q  <= match_seen_q ? offset_q : '0;
		end else if (drain_step) begin
			out_byte_q <= cell_q[drain_pos[wssp_pkg::IDX_W-1:0]];
			out_last_q <= fill_q == ONE;
			found_q    <= match_seen_q;
			out_ofs_q  <= match_seen_q ? offset_q : '0;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.out_byte     = out_byte_q;
	assign result_ch.out_last     = out_last_q;
	assign result_ch.found        = found_q;
	assign result_ch.match_offset = out_ofs_q;

endmodule

### rtl/wssp_cell.sv
// One byte of the delay line: takes its neighbor's byte on each shift,
// compares the incoming byte against its pattern slot and applies the patch.
module wssp_cell (
	input  logic                            clk,
	input  logic [wssp_pkg::IDX_W-1:0]      pos,
	input  wssp_pkg::cell_cfg_t             cfg,
	input  logic                            shift,
	input  logic [wssp_pkg::BYTE_W-1:0]     din,
	input  logic                            hit,
	output logic                            match,
	output logic [wssp_pkg::BYTE_W-1:0]     q
);

	logic [wssp_pkg::CNT_W:0]     reach;
	logic [wssp_pkg::CNT_W:0]     slot_full;
	logic [wssp_pkg::IDX_W-1:0]   slot;
	logic                         in_win;
	logic                         patch;
	logic [wssp_pkg::BYTE_W-1:0]  byte_q;

	// slot of the pattern this cell sees once the line has shifted
	assign reach     = (wssp_pkg::CNT_W + 1)'(pos) + (wssp_pkg::CNT_W + 1)'(cfg.pat_len);
	assign in_win    = reach >= (wssp_pkg::CNT_W + 1)'(wssp_pkg::MAX_PATTERN);
	assign slot_full = reach - (wssp_pkg::CNT_W + 1)'(wssp_pkg::MAX_PATTERN);
	assign slot      = slot_full[wssp_pkg::IDX_W-1:0];

	// wildcard slots and cells outside the window always agree
	assign match = !in_win || !cfg.care[slot]
		|| (din == wssp_pkg::pick_byte(cfg.pattern, slot));

	assign patch = in_win && (wssp_pkg::CNT_W'(slot) < cfg.in_len) && cfg.wmask[slot];

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= (hit && patch) ? wssp_pkg::pick_byte(cfg.replace, slot) : din;
		end
	end

	assign q = byte_q;

endmodule

### rtl/wssp_checker.sv
`include "wildcard_signature_scan_patch_macros.svh"

// Port-level checks of the scan and patch block.
module wssp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            in_last,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [wssp_pkg::BYTE_W-1:0]     out_byte,
	input  logic                            out_last,
	input  logic                            found,
	input  logic [wssp_pkg::OFS_W-1:0]      match_offset
);

	// a stalled result keeps its payload
	`WSSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(found) && $stable(match_offset), "stalled result changed")

	// the last input byte starts the drain, which takes no further input
	`WSSP_ASSERT_NEXT(a_drain_blocks, in_valid && in_ready && in_last, !in_ready, "input taken during drain")

	// once a stream reports a match, later results of that stream keep it
	`WSSP_ASSERT_NEXT(a_found_sticky, out_valid && out_ready && found && !out_last, !out_valid || found, "found dropped mid-stream")

	// the offset reads zero until a match is reported
	`WSSP_ASSERT_SAME(a_offset_zero, out_valid && !found, match_offset == '0, "offset set without a match")

endmodule

bind wildcard_signature_scan_patch wssp_checker u_wssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (byte_ch.valid),
	.in_ready     (byte_ch.ready),
	.in_last      (byte_ch.in_last),
	.out_valid    (result_ch.valid),
	.out_ready    (result_ch.ready),
	.out_byte     (result_ch.out_byte),
	.out_last     (result_ch.out_last),
	.found        (result_ch.found),
	.match_offset (result_ch.match_offset)
);
